>>> rtl/csikq_pkg.sv
package csikq_pkg;

  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_MAX_SEQUENCE = 127;
  localparam int DEF_MAX_PARAMS   = 5;

  localparam int KEY_W  = 8;
  localparam int WAIT_W = 5;
  localparam int CMD_W  = 3;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam int KEY_LO  = 0;
  localparam int WAIT_LO = KEY_LO + KEY_W;
  localparam int DROP_B  = WAIT_LO + WAIT_W;
  localparam int CMD_LO  = DROP_B + 1;
  localparam int DBG_B   = CMD_LO + CMD_W;
  localparam int ERR_B   = DBG_B + 1;
  localparam int PAD_W   = OUT_DATA_W - ERR_B - 1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STEP_INTO = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEP_OVER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 3'd4;

  typedef struct packed {
    logic             push;
    logic [CMD_W-1:0] command;
    logic             debug_on;
    logic             sequence_error;
  } csikq_parse_t;

  typedef struct packed {
    logic              pop_hit;
    logic              dropped;
    logic [WAIT_W-1:0] waiting;
  } csikq_qstat_t;

endpackage

>>> rtl/csikq_ram.sv
module csikq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/csikq_queue.sv
module csikq_queue #(
  parameter int QUEUE_DEPTH = csikq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       operation,
  input  logic                       push,
  input  logic [csikq_pkg::KEY_W-1:0] input_byte,
  output csikq_pkg::csikq_qstat_t     stat,
  output logic [csikq_pkg::KEY_W-1:0] rd_key
);
  import csikq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             full, empty, do_push, do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = accept && (operation == OP_BYTE) && push && !full;
  assign do_pop  = accept && (operation == OP_POP) && !empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      count_next  = CNT_W'(count + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      count_next  = CNT_W'(count - 1'b1);
    end
  end

  always_comb begin
    stat.pop_hit = (operation == OP_POP) && !empty;
    stat.dropped = (operation == OP_BYTE) && push && full;
    stat.waiting = WAIT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  csikq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(wr_ptr),
    .wdata(input_byte),
    .re   (do_pop),
    .raddr(rd_ptr),
    .rdata(rd_key)
  );

endmodule

>>> rtl/csikq_parser.sv
module csikq_parser #(
  parameter int MAX_SEQUENCE = csikq_pkg::DEF_MAX_SEQUENCE,
  parameter int MAX_PARAMS   = csikq_pkg::DEF_MAX_PARAMS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_data,
  input  logic                        accept,
  input  logic                        operation,
  input  logic [csikq_pkg::KEY_W-1:0] input_byte,
  output csikq_pkg::csikq_parse_t     res
);
  import csikq_pkg::*;

  localparam int LEN_W = $clog2(MAX_SEQUENCE + 1);
  localparam int IDX_W = $clog2(MAX_PARAMS + 1);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_OTHER   = 3'd2;
  localparam logic [2:0] PH_START   = 3'd3;
  localparam logic [2:0] PH_DIGITS  = 3'd4;
  localparam logic [2:0] PH_FULL    = 3'd5;
  localparam logic [2:0] PH_DECIDED = 3'd6;

  localparam logic [7:0] ESC_BYTE  = 8'h1b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] TERM_LO   = 8'h40;
  localparam logic [7:0] TERM_HI   = 8'h7f;

  localparam logic [9:0]  PARAM_MAX = 10'd1023;
  localparam logic [9:0]  CODE_STEP_A   = 10'd24;
  localparam logic [9:0]  CODE_STEP_B   = 10'd31;
  localparam logic [9:0]  CODE_OVER_A   = 10'd23;
  localparam logic [9:0]  CODE_OVER_B   = 10'd29;
  localparam logic [9:0]  CODE_DUMP_A   = 10'd21;
  localparam logic [9:0]  CODE_DUMP_B   = 10'd28;
  localparam logic [9:0]  CODE_TOGGLE_A = 10'd20;
  localparam logic [9:0]  CODE_TOGGLE_B = 10'd26;

  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] seq_len, seq_len_next;
  logic [IDX_W-1:0] param_idx, param_idx_next;
  logic [9:0]       first_param, first_param_next;
  logic [7:0]       decide, decide_next;
  logic             debug_mode, debug_mode_next;
  logic             debug_allowed;
  logic [13:0]      prod;
  logic             ends;

  assign prod = 14'({4'b0, first_param} * 14'd10 + {10'b0, input_byte[3:0]});

  always_comb begin
    phase_next       = phase;
    seq_len_next     = seq_len;
    param_idx_next   = param_idx;
    first_param_next = first_param;
    decide_next      = decide;
    debug_mode_next  = debug_mode;
    ends             = 1'b0;
    res              = '0;
    if (operation == OP_BYTE) begin
      case (phase)
        PH_IDLE: begin
          if (input_byte == ESC_BYTE) begin
            phase_next   = PH_ESC;
            seq_len_next = '0;
          end else if (input_byte != '0) begin
            res.push = 1'b1;
          end
        end
        PH_ESC: begin
          seq_len_next     = LEN_W'(1);
          param_idx_next   = '0;
          first_param_next = '0;
          decide_next      = '0;
          phase_next       = (input_byte == CH_LBRACK) ? PH_START : PH_OTHER;
        end
        default: begin
          seq_len_next = LEN_W'(seq_len + 1'b1);
          if (phase inside {PH_START, PH_DIGITS, PH_FULL}) begin
            if (phase == PH_START && input_byte == CH_SPACE) begin
              phase_next = phase;
            end else if (phase == PH_FULL) begin
              decide_next = input_byte;
              phase_next  = PH_DECIDED;
            end else if (input_byte inside {[CH_ZERO:CH_NINE]}) begin
              if (param_idx == '0) begin
                first_param_next = (prod > 14'(PARAM_MAX)) ? PARAM_MAX : prod[9:0];
              end
              phase_next = PH_DIGITS;
            end else if (input_byte == CH_SEMI) begin
              param_idx_next = IDX_W'(param_idx + 1'b1);
              phase_next = (param_idx_next >= IDX_W'(MAX_PARAMS)) ? PH_FULL : PH_START;
            end else begin
              decide_next = input_byte;
              phase_next  = PH_DECIDED;
            end
          end
          ends = (input_byte == '0) || (input_byte inside {[TERM_LO:TERM_HI]}) ||
                 (seq_len_next >= LEN_W'(MAX_SEQUENCE));
          if (ends) begin
            if (phase == PH_OTHER) begin
              res.sequence_error = 1'b1;
            end else if (decide_next == CH_TILDE) begin
              case (first_param_next)
                CODE_STEP_A, CODE_STEP_B: begin
                  res.command = debug_mode ? CMD_STEP_INTO : CMD_NONE;
                end
                CODE_OVER_A, CODE_OVER_B: begin
                  res.command = debug_mode ? CMD_STEP_OVER : CMD_NONE;
                end
                CODE_DUMP_A, CODE_DUMP_B: begin
                  res.command = debug_mode ? CMD_DUMP : CMD_NONE;
                end
                CODE_TOGGLE_A, CODE_TOGGLE_B: begin
                  if (debug_allowed) begin
                    debug_mode_next = !debug_mode;
                    res.command     = CMD_TOGGLE;
                  end
                end
                default: begin
                  res.sequence_error = 1'b1;
                end
              endcase
            end
            phase_next       = PH_IDLE;
            seq_len_next     = '0;
            param_idx_next   = '0;
            first_param_next = '0;
            decide_next      = '0;
          end
        end
      endcase
    end
    res.debug_on = debug_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      seq_len       <= '0;
      param_idx     <= '0;
      first_param   <= '0;
      decide        <= '0;
      debug_mode    <= 1'b0;
      debug_allowed <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        seq_len     <= seq_len_next;
        param_idx   <= param_idx_next;
        first_param <= first_param_next;
        decide      <= decide_next;
        debug_mode  <= debug_mode_next;
      end
      if (cfg_we) begin
        debug_allowed <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/csi_key_input_parser_fifo.sv
// Path: an accepted word loads the key RAM read and the stage register, then the output
// register when the output can take it; m_tvalid rises with the output register.
// Throughput: one word per cycle; input stalls only when both pipeline registers are full.
// Reset (rst, synchronous): clears queue pointers and count, parser state, debug mode and
// debug_allowed. The key RAM is not cleared and needs no sweep; ready right after reset.
module csi_key_input_parser_fifo #(
  parameter int QUEUE_DEPTH  = csikq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_SEQUENCE = csikq_pkg::DEF_MAX_SEQUENCE,
  parameter int MAX_PARAMS   = csikq_pkg::DEF_MAX_PARAMS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,   // debug_allowed
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [csikq_pkg::IN_DATA_W-1:0]  s_tdata,    // input_byte
  input  logic                             s_tuser,    // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // popped_key[7:0], keys_waiting[12:8], key_dropped[13], command[16:14],
  // debug_on[17], sequence_error[18], zero pad
  output logic [csikq_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tuser     // key_valid
);
  import csikq_pkg::*;

  logic         accept, s1_adv, s1_valid;
  csikq_parse_t parse_res, s1_parse;
  csikq_qstat_t qstat, s1_q;
  logic [KEY_W-1:0] rd_key, popped;

  assign cfg_ready = 1'b1;
  assign s_tready  = !s1_valid || !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign s1_adv    = s1_valid && (!m_tvalid || m_tready);
  assign popped    = s1_q.pop_hit ? rd_key : '0;

  csikq_parser #(
    .MAX_SEQUENCE(MAX_SEQUENCE),
    .MAX_PARAMS  (MAX_PARAMS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .operation (s_tuser),
    .input_byte(s_tdata[KEY_W-1:0]),
    .res       (parse_res)
  );

  csikq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser),
    .push      (parse_res.push),
    .input_byte(s_tdata[KEY_W-1:0]),
    .stat      (qstat),
    .rd_key    (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_parse <= parse_res;
      s1_q     <= qstat;
    end
    if (s1_adv) begin
      m_tdata <= {{PAD_W{1'b0}}, s1_parse.sequence_error, s1_parse.debug_on,
                  s1_parse.command, s1_q.dropped, s1_q.waiting, popped};
      m_tuser <= s1_q.pop_hit;
    end
  end

endmodule

>>> rtl/csikq_checker.sv
module csikq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [csikq_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                             m_tuser
);
  import csikq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[DROP_B] && !m_tdata[ERR_B] &&
                            (m_tdata[CMD_LO +: CMD_W] == CMD_NONE))
    else $error("pop word carries parser or drop flags");

  a_nokey_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[KEY_LO +: KEY_W] == '0))
    else $error("popped key nonzero without key_valid");

  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[DROP_B] || m_tdata[ERR_B]) |->
      (m_tdata[CMD_LO +: CMD_W] == CMD_NONE) && !(m_tdata[DROP_B] && m_tdata[ERR_B]))
    else $error("drop, error and command overlap");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind csi_key_input_parser_fifo csikq_checker u_csikq_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

>>> tb/sv/tb_csi_key_input_parser_fifo.sv
`timescale 1ns / 1ps

module tb_csi_key_input_parser_fifo;
  import csikq_pkg::*;

  localparam logic [7:0] ESC_CODE  = 8'h1b;
  localparam logic [7:0] LBRACKET  = 8'h5b;
  localparam logic [7:0] TILDE     = 8'h7e;
  localparam logic [7:0] SEMICOLON = 8'h3b;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7f;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  localparam int CODE_TOGGLE_A = 20;
  localparam int CODE_DUMP_A   = 21;
  localparam int CODE_OVER_A   = 23;
  localparam int CODE_STEP_A   = 24;
  localparam int CODE_TOGGLE_B = 26;
  localparam int CODE_DUMP_B   = 28;
  localparam int CODE_OVER_B   = 29;
  localparam int CODE_STEP_B   = 31;
  localparam int PARAM_CEIL    = 1023;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_OTHER, ST_START, ST_DIGITS, ST_FULL, ST_DECIDED
  } parse_state_t;

  typedef struct packed {
    logic              key_valid;
    logic [KEY_W-1:0]  key;
    logic [WAIT_W-1:0] waiting;
    logic              dropped;
    logic [CMD_W-1:0]  command;
    logic              debug_on;
    logic              seq_error;
  } key_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  csi_key_input_parser_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // key queue and parser image
  logic [KEY_W-1:0] key_mem [DEF_QUEUE_DEPTH];
  int               q_head = 0;
  int               q_tail = 0;
  int               q_fill = 0;
  parse_state_t     pstate = ST_IDLE;
  int               seq_count = 0;
  int               param_idx = 0;
  int               param0 = 0;
  logic [7:0]       final_byte = '0;
  logic             dbg_mode = 1'b0;
  logic             dbg_allowed = 1'b0;

  key_result_t pending_results[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_long_hold = 0;

  int tilde_codes[8] = '{CODE_TOGGLE_A, CODE_DUMP_A, CODE_OVER_A, CODE_STEP_A,
                         CODE_TOGGLE_B, CODE_DUMP_B, CODE_OVER_B, CODE_STEP_B};

  function automatic key_result_t predict_key_result(logic op, logic [7:0] b);
    key_result_t r;
    int          v;
    logic        ends;
    r = '0;
    if (op == OP_POP) begin
      if (q_fill > 0) begin
        r.key_valid = 1'b1;
        r.key = key_mem[q_tail];
        q_tail = (q_tail + 1) % DEF_QUEUE_DEPTH;
        q_fill--;
      end
    end else if (pstate == ST_IDLE) begin
      if (b == ESC_CODE) begin
        pstate = ST_ESC;
        seq_count = 0;
      end else if (b != NUL_BYTE) begin
        if (q_fill >= DEF_QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          key_mem[q_head] = b;
          q_head = (q_head + 1) % DEF_QUEUE_DEPTH;
          q_fill++;
        end
      end
    end else if (pstate == ST_ESC) begin
      seq_count = 1;
      param_idx = 0;
      param0 = 0;
      final_byte = '0;
      pstate = (b == LBRACKET) ? ST_START : ST_OTHER;
    end else begin
      seq_count++;
      if (pstate != ST_OTHER && pstate != ST_DECIDED) begin
        if (pstate == ST_START && b == SPACE) begin
        end else if (pstate == ST_FULL) begin
          final_byte = b;
          pstate = ST_DECIDED;
        end else if (b >= DIGIT_0 && b <= DIGIT_9) begin
          if (param_idx == 0) begin
            v = param0 * 10 + int'(b - DIGIT_0);
            param0 = (v > PARAM_CEIL) ? PARAM_CEIL : v;
          end
          pstate = ST_DIGITS;
        end else if (b == SEMICOLON) begin
          param_idx++;
          pstate = (param_idx >= DEF_MAX_PARAMS) ? ST_FULL : ST_START;
        end else begin
          final_byte = b;
          pstate = ST_DECIDED;
        end
      end
      ends = (b == NUL_BYTE) || (b >= FINAL_LO && b <= FINAL_HI) ||
             (seq_count >= DEF_MAX_SEQUENCE);
      if (ends) begin
        if (pstate == ST_OTHER) begin
          r.seq_error = 1'b1;
        end else if (final_byte == TILDE) begin
          case (param0)
            CODE_STEP_A, CODE_STEP_B:     r.command = dbg_mode ? CMD_STEP_INTO : CMD_NONE;
            CODE_OVER_A, CODE_OVER_B:     r.command = dbg_mode ? CMD_STEP_OVER : CMD_NONE;
            CODE_DUMP_A, CODE_DUMP_B:     r.command = dbg_mode ? CMD_DUMP : CMD_NONE;
            CODE_TOGGLE_A, CODE_TOGGLE_B: begin
              if (dbg_allowed) begin
                dbg_mode = ~dbg_mode;
                r.command = CMD_TOGGLE;
              end
            end
            default: r.seq_error = 1'b1;
          endcase
        end
        pstate = ST_IDLE;
        seq_count = 0;
        param_idx = 0;
        param0 = 0;
        final_byte = '0;
      end
    end
    r.waiting = q_fill[WAIT_W-1:0];
    r.debug_on = dbg_mode;
    return r;
  endfunction

  task automatic log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    key_result_t want;
    key_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.key_valid = m_tuser;
      got.key       = m_tdata[KEY_LO +: KEY_W];
      got.waiting   = m_tdata[WAIT_LO +: WAIT_W];
      got.dropped   = m_tdata[DROP_B];
      got.command   = m_tdata[CMD_LO +: CMD_W];
      got.debug_on  = m_tdata[DBG_B];
      got.seq_error = m_tdata[ERR_B];
      if (pending_results.size() == 0) begin
        log_fail($sformatf("unexpected result word at %0t", $realtime));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          log_fail($sformatf({"mismatch at %0t: expected valid=%0d key=%02h wait=%0d ",
                              "drop=%0d cmd=%0d dbg=%0d err=%0d, got valid=%0d key=%02h ",
                              "wait=%0d drop=%0d cmd=%0d dbg=%0d err=%0d"},
                             $realtime, want.key_valid, want.key, want.waiting,
                             want.dropped, want.command, want.debug_on, want.seq_error,
                             got.key_valid, got.key, got.waiting, got.dropped,
                             got.command, got.debug_on, got.seq_error));
      end
    end
  end

  // receiver: random stall bursts plus the long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && rx_long_hold > 0) begin
        stall_left = rx_long_hold;
        rx_long_hold = 0;
      end else if (stall_left == 0 && rx_idle_pct > 0 &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    @(negedge clk);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_key_result(op, b));
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    int k;
    for (k = 0; k < txt.len(); k++) send_word(OP_BYTE, txt[k]);
  endtask

  // interleave pops into sequences now and then
  task automatic send_seq_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) send_word(OP_POP, 8'($urandom_range(0, 255)));
    send_word(OP_BYTE, b);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debug_allowed(input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    dbg_allowed = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_csi_sequence();
    int    nparam;
    int    i;
    int    k;
    int    val;
    int    pick;
    string digits;
    send_seq_byte(ESC_CODE);
    send_seq_byte(LBRACKET);
    nparam = $urandom_range(0, 6);
    for (i = 0; i < nparam; i++) begin
      if (i > 0) send_seq_byte(SEMICOLON);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) send_seq_byte(SPACE);
      pick = $urandom_range(0, 9);
      if (pick < 6) val = tilde_codes[$urandom_range(0, 7)];
      else if (pick < 8) val = $urandom_range(0, 99);
      else if (pick < 9) val = $urandom_range(0, 99999);
      else val = -1;
      if (val >= 0) begin
        if ($urandom_range(0, 19) == 0) send_seq_byte(DIGIT_0);
        digits = $sformatf("%0d", val);
        for (k = 0; k < digits.len(); k++) send_seq_byte(digits[k]);
      end
    end
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      send_seq_byte(TILDE);
    end else if (pick < 18) begin
      send_seq_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
    end else if (pick < 19) begin
      send_seq_byte(NUL_BYTE);
    end else begin
      send_seq_byte(8'($urandom_range(8'h21, 8'h2f)));
      send_seq_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
    end
  endtask

  task automatic send_other_sequence();
    logic [7:0] second;
    send_seq_byte(ESC_CODE);
    do second = 8'($urandom_range(0, 255)); while (second == LBRACKET);
    send_seq_byte(second);
    repeat ($urandom_range(0, 3)) send_seq_byte(8'($urandom_range(8'h20, 8'h3f)));
    if ($urandom_range(0, 5) == 0) send_seq_byte(NUL_BYTE);
    else send_seq_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
  endtask

  // bytes that never terminate, so the length limit closes the sequence
  task automatic send_long_sequence();
    send_word(OP_BYTE, ESC_CODE);
    send_word(OP_BYTE, ($urandom_range(0, 1) == 0) ? LBRACKET : 8'h21);
    repeat (DEF_MAX_SEQUENCE - 1 + $urandom_range(0, 3))
      send_word(OP_BYTE, 8'($urandom_range(8'h20, 8'h3f)));
  endtask

  task automatic run_mixed_traffic(input int n_items);
    int         first;
    int         kind;
    logic [7:0] b;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 199);
      if (kind < 60) begin
        do b = 8'($urandom_range(1, 255)); while (b == ESC_CODE);
        send_word(OP_BYTE, b);
      end else if (kind < 100) begin
        send_word(OP_POP, 8'($urandom_range(0, 255)));
      end else if (kind < 160) begin
        send_csi_sequence();
      end else if (kind < 180) begin
        send_other_sequence();
      end else if (kind < 199) begin
        send_word(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_long_sequence();
      end
    end
  endtask

  task automatic test_directed_cases();
    write_debug_allowed(1'b0);
    send_word(OP_POP, 8'hff);
    send_word(OP_BYTE, NUL_BYTE);
    send_word(OP_BYTE, 8'hff);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_POP, 8'h00);
    send_word(OP_BYTE, ESC_CODE);
    send_text("[20~");
    drain_results();
    write_debug_allowed(1'b1);
    send_word(OP_BYTE, ESC_CODE);
    send_text("[26~");
    send_word(OP_BYTE, ESC_CODE);
    send_text("[ 31~");
    send_word(OP_BYTE, ESC_CODE);
    send_text("xA");
    send_word(OP_BYTE, ESC_CODE);
    send_text("[99~");
    drain_results();
  endtask

  task automatic test_random_allowed();
    tx_idle_pct = 8;
    rx_idle_pct = 8;
    run_mixed_traffic(400);
    drain_results();
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    rx_long_hold = 120;
    repeat (48) begin
      do b = 8'($urandom_range(1, 255)); while (b == ESC_CODE);
      send_word(OP_BYTE, b);
    end
    drain_results();
    repeat (20) send_word(OP_POP, 8'($urandom_range(0, 255)));
    drain_results();
  endtask

  task automatic test_random_locked();
    write_debug_allowed(1'b0);
    tx_idle_pct = 15;
    rx_idle_pct = 4;
    run_mixed_traffic(300);
    drain_results();
  endtask

  task automatic test_full_rate();
    write_debug_allowed(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mixed_traffic(450);
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_allowed();
    test_backpressure();
    test_random_locked();
    test_full_rate();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("csi_key_input_parser_fifo test passed");
    end else begin
      $display("csi_key_input_parser_fifo test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("csi_key_input_parser_fifo test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/csikq_pkg.sv
rtl/csikq_ram.sv
rtl/csikq_queue.sv
rtl/csikq_parser.sv
rtl/csi_key_input_parser_fifo.sv
rtl/csikq_checker.sv
tb/sv/tb_csi_key_input_parser_fifo.sv
